/* sv/r2q_pkg.sv */
// Shared constants and types for the rotation matrix to quaternion block.
package r2q_pkg;

    localparam int FRAC_BITS = 14;
    localparam int DW        = 16;
    localparam int QW        = (FRAC_BITS + 3 > 18) ? FRAC_BITS + 3 : 18;
    localparam int MW        = QW - 1;
    localparam int SQW       = 2 * MW;
    localparam int SW        = SQW + 2;
    localparam int RB        = 15;
    localparam int EA        = SQW + 2 * FRAC_BITS + 4;
    localparam int EB        = SW + 2 * RB + 6;
    localparam int EW        = (EA > EB) ? EA : EB;
    localparam int RSH       = 2 * FRAC_BITS + 2;

    localparam logic [1:0] BR_W = 2'd0;
    localparam logic [1:0] BR_Z = 2'd1;
    localparam logic [1:0] BR_Y = 2'd2;
    localparam logic [1:0] BR_X = 2'd3;

    // unnormalized quaternion, order x y z w
    typedef struct packed {
        logic [3:0][QW-1:0] q;
        logic [1:0]         br;
        logic               inv;
    } t_item;

    typedef struct packed {
        logic signed [EW-1:0] e;
        logic signed [EW-1:0] t;
        logic [RB-1:0]        r;
    } t_lane;

    typedef struct packed {
        t_lane [3:0]   ln;
        logic [SW-1:0] s;
        logic [3:0]    sgn;
        logic [1:0]    br;
        logic          inv;
    } t_iter;

endpackage

/* sv/r2q_front.sv */
// Front end: branch selection and off-diagonal sums, one item per ready cycle.
module r2q_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [9*r2q_pkg::DW-1:0] i_data,
    output logic                 o_valid,
    input  logic                 i_ready,
    output r2q_pkg::t_item       o_item
);

    logic                 r_vld;
    r2q_pkg::t_item       r_item;
    r2q_pkg::t_item       n_item;
    logic signed [r2q_pkg::QW-1:0] m [0:8];
    logic signed [r2q_pkg::QW-1:0] one;
    logic signed [r2q_pkg::QW-1:0] trace;
    logic signed [r2q_pkg::QW-1:0] arg;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            m[k] = r2q_pkg::QW'($signed(i_data[k*r2q_pkg::DW +: r2q_pkg::DW]));
        end
    end

    assign one   = r2q_pkg::QW'(1) <<< r2q_pkg::FRAC_BITS;
    assign trace = m[0] + m[4] + m[8];

    // m index: 0 xx 1 xy 2 xz 3 yx 4 yy 5 yz 6 zx 7 zy 8 zz
    always_comb begin
        if (trace > 0) begin
            arg        = trace + one;
            n_item.br  = r2q_pkg::BR_W;
            n_item.q[0] = m[5] - m[7];
            n_item.q[1] = m[6] - m[2];
            n_item.q[2] = m[1] - m[3];
            n_item.q[3] = arg;
        end else if (m[8] > m[0] && m[8] > m[4]) begin
            arg        = m[8] - m[0] - m[4] + one;
            n_item.br  = r2q_pkg::BR_Z;
            n_item.q[0] = m[2] + m[6];
            n_item.q[1] = m[5] + m[7];
            n_item.q[2] = arg;
            n_item.q[3] = m[1] - m[3];
        end else if (m[4] > m[0]) begin
            arg        = m[4] - m[8] - m[0] + one;
            n_item.br  = r2q_pkg::BR_Y;
            n_item.q[0] = m[1] + m[3];
            n_item.q[1] = arg;
            n_item.q[2] = m[7] + m[5];
            n_item.q[3] = m[6] - m[2];
        end else begin
            arg        = m[0] - m[4] - m[8] + one;
            n_item.br  = r2q_pkg::BR_X;
            n_item.q[0] = arg;
            n_item.q[1] = m[3] + m[1];
            n_item.q[2] = m[6] + m[2];
            n_item.q[3] = m[5] - m[7];
        end
        n_item.inv = (arg <= 0);
    end

    assign o_ready = !r_vld || i_ready;
    assign o_valid = r_vld;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

/* sv/r2q_fifo.sv */
// Four-entry queue between front and back end.
module r2q_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  r2q_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output r2q_pkg::t_item o_item
);

    r2q_pkg::t_item r_mem [0:3];
    logic [1:0]     r_wp;
    logic [1:0]     r_rp;
    logic [2:0]     r_cnt;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 2'd1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 2'd1;
            end
            r_cnt <= r_cnt + {2'd0, i_push} - {2'd0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push) else $error("queue overflow");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop) else $error("queue underflow");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd4) else $error("queue count out of range");
`endif

endmodule

/* sv/r2q_back.sv */
// Back end: squares, length sum and pipelined bit-per-stage normalization.
module r2q_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  r2q_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [4*r2q_pkg::DW-1:0] o_quat,
    output logic [1:0]     o_branch,
    output logic           o_invalid
);

    localparam int NS = r2q_pkg::RB;

    logic                                   en;
    logic                                   r_v0;
    logic [3:0][r2q_pkg::SQW-1:0]           r_sq;
    logic [3:0]                             r_sgn;
    logic [1:0]                             r_br;
    logic                                   r_inv;
    logic                                   r_itv [0:NS];
    r2q_pkg::t_iter                         r_it  [0:NS];
    r2q_pkg::t_iter                         n_it  [0:NS];
    logic                                   r_ov;
    logic [4*r2q_pkg::DW-1:0]               r_quat;
    logic [1:0]                             r_obr;
    logic                                   r_oinv;
    logic [4*r2q_pkg::DW-1:0]               n_quat;

    assign en    = !r_ov || i_ready;
    assign o_pop = en && !i_empty;

    // stage 0: magnitudes squared
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [r2q_pkg::MW-1:0] mg;
        if (o_pop) begin
            for (int k = 0; k < 4; k++) begin
                mg = i_item.q[k][r2q_pkg::QW-1] ? r2q_pkg::MW'(-i_item.q[k])
                                                : r2q_pkg::MW'(i_item.q[k]);
                r_sq[k]  <= mg * mg;
                r_sgn[k] <= i_item.q[k][r2q_pkg::QW-1];
            end
            r_br  <= i_item.br;
            r_inv <= i_item.inv;
        end
    end

    // stage 1: length sum, residual set to rhs - s, t = -s
    always_comb begin
        logic [r2q_pkg::SW-1:0]        s;
        logic signed [r2q_pkg::EW-1:0] se;
        s  = r2q_pkg::SW'(r_sq[0]) + r2q_pkg::SW'(r_sq[1])
           + r2q_pkg::SW'(r_sq[2]) + r2q_pkg::SW'(r_sq[3]);
        se = $signed(r2q_pkg::EW'(s));
        n_it[0].s   = s;
        n_it[0].sgn = r_sgn;
        n_it[0].br  = r_br;
        n_it[0].inv = r_inv;
        for (int k = 0; k < 4; k++) begin
            n_it[0].ln[k].e = ($signed(r2q_pkg::EW'(r_sq[k])) <<< r2q_pkg::RSH) - se;
            n_it[0].ln[k].t = -se;
            n_it[0].ln[k].r = '0;
        end
    end

    // stage i+1: try bit RB-1-i; k^2*s tracked incrementally by shifts and adds
    for (genvar i = 0; i < NS; i++) begin : g_it
        localparam int SB = NS - 1 - i;
        always_comb begin
            logic signed [r2q_pkg::EW-1:0] se;
            logic signed [r2q_pkg::EW-1:0] cand;
            se = $signed(r2q_pkg::EW'(r_it[i].s));
            n_it[i+1] = r_it[i];
            for (int k = 0; k < 4; k++) begin
                cand = r_it[i].ln[k].e - ((r_it[i].ln[k].t <<< (SB + 2))
                                         + (se <<< (2 * SB + 2)));
                if (cand >= 0) begin
                    n_it[i+1].ln[k].e = cand;
                    n_it[i+1].ln[k].t = r_it[i].ln[k].t + (se <<< (SB + 1));
                    n_it[i+1].ln[k].r = r_it[i].ln[k].r | (r2q_pkg::RB'(1) << SB);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= NS; j++) begin
                r_itv[j] <= 1'b0;
            end
        end else if (en) begin
            r_itv[0] <= r_v0;
            for (int j = 1; j <= NS; j++) begin
                r_itv[j] <= r_itv[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int j = 0; j <= NS; j++) begin
                r_it[j] <= n_it[j];
            end
        end
    end

    // output stage: apply sign, zero invalid items
    always_comb begin
        logic signed [r2q_pkg::DW-1:0] mv;
        for (int k = 0; k < 4; k++) begin
            mv = $signed(r2q_pkg::DW'(r_it[NS].ln[k].r));
            if (r_it[NS].inv) begin
                n_quat[k*r2q_pkg::DW +: r2q_pkg::DW] = '0;
            end else if (r_it[NS].sgn[k]) begin
                n_quat[k*r2q_pkg::DW +: r2q_pkg::DW] = -mv;
            end else begin
                n_quat[k*r2q_pkg::DW +: r2q_pkg::DW] = mv;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov <= r_itv[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_quat <= n_quat;
            r_obr  <= r_it[NS].br;
            r_oinv <= r_it[NS].inv;
        end
    end

    assign o_valid   = r_ov;
    assign o_quat    = r_quat;
    assign o_branch  = r_obr;
    assign o_invalid = r_oinv;

`ifndef NO_ASSERTIONS
    a_inv_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_invalid) |-> (o_quat == '0)) else $error("invalid item not zeroed");
    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat[r2q_pkg::DW-1:0] != {1'b1, {(r2q_pkg::DW-1){1'b0}}}))
        else $error("component below -32767");
    a_w_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_invalid && o_branch == r2q_pkg::BR_W)
            |-> !o_quat[4*r2q_pkg::DW-1]) else $error("w negative on w branch");
    a_w_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_branch == r2q_pkg::BR_W) |-> !o_invalid)
        else $error("w branch flagged invalid");
`endif

endmodule

/* sv/rotation_matrix_to_quaternion.sv */
// Pipeline from input accept to result valid: front register, queue, squares,
// length sum, 15 normalization stages, output register.
// Throughput: one item per cycle unless the output stalls; the 15-stage bit-per-stage
// normalization pipeline and four-entry queue between front and back end sustain it.
// Reset (synchronous, active low) empties the queue and all stage valid bits.
module rotation_matrix_to_quaternion (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // col0_x, col0_y, col0_z, col1_x, col1_y, col1_z, col2_x, col2_y, col2_z
    input  logic [143:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // quat_x, quat_y, quat_z, quat_w
    output logic [63:0] m_tdata,
    // branch_taken[1:0], invalid[2]
    output logic [2:0]  m_tuser
);

    logic           f_valid;
    logic           q_full;
    logic           q_empty;
    logic           q_pop;
    r2q_pkg::t_item f_item;
    r2q_pkg::t_item q_item;
    logic [1:0]     br;
    logic           inv;

    r2q_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_data  (s_tdata),
        .o_valid (f_valid),
        .i_ready (!q_full),
        .o_item  (f_item)
    );

    r2q_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid && !q_full),
        .i_item  (f_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_item)
    );

    r2q_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_empty   (q_empty),
        .i_item    (q_item),
        .o_pop     (q_pop),
        .o_valid   (m_tvalid),
        .i_ready   (m_tready),
        .o_quat    (m_tdata),
        .o_branch  (br),
        .o_invalid (inv)
    );

    assign m_tuser = {inv, br};

endmodule

/* test/tb_rotation_matrix_to_quaternion.sv */
// Testbench for the rotation matrix to quaternion block: directed and random matrices.
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;

    localparam int MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [15:0] qx;
        logic signed [15:0] qy;
        logic signed [15:0] qz;
        logic signed [15:0] qw;
        logic [1:0]         br;
        logic               inv;
    } t_quat;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [63:0]  m_tdata;
    logic [2:0]   m_tuser;

    t_quat quat_q[$];
    int    errors = 0;
    int    cycles = 0;
    int    stall = 0;
    bit    sink_run = 1'b0;

    rotation_matrix_to_quaternion dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("tb_rotation_matrix_to_quaternion NOT OK");
            $finish;
        end
    end

    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // round(v * 2^FRAC_BITS / sqrt(s)) by bitwise search, halves away from zero
    function automatic logic signed [15:0] scale_comp(longint v, longint unsigned s);
        longint unsigned mag, r, c, k;
        logic [127:0] rhs, lhs;
        mag = (v < 0) ? -v : v;
        rhs = 128'(mag * mag) << (2 * r2q_pkg::FRAC_BITS + 2);
        r = 0;
        for (int b = 14; b >= 0; b--) begin
            c = r | (64'd1 << b);
            k = 2 * c - 1;
            lhs = 128'(k * k) * 128'(s);
            if (lhs <= rhs) r = c;
        end
        return (v < 0) ? -16'(r) : 16'(r);
    endfunction

    function automatic t_quat predict_quat(logic [143:0] d);
        longint m[9];
        longint q[4];
        longint one, arg;
        longint unsigned s;
        t_quat e;
        for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
        one = longint'(1) << r2q_pkg::FRAC_BITS;
        // m: 0 xx 1 xy 2 xz 3 yx 4 yy 5 yz 6 zx 7 zy 8 zz
        if (m[0] + m[4] + m[8] > 0) begin
            e.br = r2q_pkg::BR_W; arg = m[0] + m[4] + m[8] + one;
            q[0] = m[5] - m[7]; q[1] = m[6] - m[2]; q[2] = m[1] - m[3]; q[3] = arg;
        end else if (m[8] > m[0] && m[8] > m[4]) begin
            e.br = r2q_pkg::BR_Z; arg = m[8] - m[0] - m[4] + one;
            q[0] = m[2] + m[6]; q[1] = m[5] + m[7]; q[2] = arg; q[3] = m[1] - m[3];
        end else if (m[4] > m[0]) begin
            e.br = r2q_pkg::BR_Y; arg = m[4] - m[8] - m[0] + one;
            q[0] = m[1] + m[3]; q[1] = arg; q[2] = m[7] + m[5]; q[3] = m[6] - m[2];
        end else begin
            e.br = r2q_pkg::BR_X; arg = m[0] - m[4] - m[8] + one;
            q[0] = arg; q[1] = m[3] + m[1]; q[2] = m[6] + m[2]; q[3] = m[5] - m[7];
        end
        if (arg <= 0) begin
            e.qx = 0; e.qy = 0; e.qz = 0; e.qw = 0; e.inv = 1'b1;
            return e;
        end
        s = 0;
        for (int i = 0; i < 4; i++) s += longint'(q[i] * q[i]);
        e.qx = scale_comp(q[0], s);
        e.qy = scale_comp(q[1], s);
        e.qz = scale_comp(q[2], s);
        e.qw = scale_comp(q[3], s);
        e.inv = 1'b0;
        return e;
    endfunction

    // drop valid only when a gap follows; the caller drops it after the last item
    task automatic send_matrix(logic [143:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        s_tdata  <= d;
        s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        quat_q.push_back(predict_quat(d));
    endtask

    task automatic send_cols(int xx, int xy, int xz, int yx, int yy, int yz,
                             int zx, int zy, int zz);
        send_matrix({16'(zz), 16'(zy), 16'(zx), 16'(yz), 16'(yy), 16'(yx),
                     16'(xz), 16'(xy), 16'(xx)});
    endtask

    // ready toggles randomly with some long stalls
    always @(posedge i_clk) begin
        if (!sink_run) begin
            m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall    <= stall - 1;
            m_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 3) begin
            stall    <= $urandom_range(8, 30);
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) < 75);
        end
    end

    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = {m_tdata[15:0], m_tdata[31:16], m_tdata[47:32], m_tdata[63:48],
                   m_tuser[1:0], m_tuser[2]};
            if (quat_q.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
            end else begin
                want = quat_q.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected x %0d y %0d z %0d w %0d br %0d inv %0b",
                             $time, want.qx, want.qy, want.qz, want.qw, want.br, want.inv);
                    $display("%0t:          actual   x %0d y %0d z %0d w %0d br %0d inv %0b",
                             $time, got.qx, got.qy, got.qz, got.qw, got.br, got.inv);
                    errors++;
                end
            end
        end
    end

    task automatic test_directed();
        localparam int ONE = 16384;
        send_cols(ONE, 0, 0, 0, ONE, 0, 0, 0, ONE);
        send_cols(-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE);
        send_cols(-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE);
        send_cols(ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE);
        send_cols(0, ONE, 0, -ONE, 0, 0, 0, 0, ONE);
        send_cols(0, 0, 0, 0, 0, 0, 0, 0, 0);
        // ties fall through to later branches
        send_cols(-100, 0, 0, 0, -100, 0, 0, 0, -100);
        send_cols(-200, 7, 3, 5, -100, 9, 1, 2, -100);
        send_cols(-100, 7, 3, 5, -100, 9, 1, 2, -200);
        // full-scale and bit-pattern entries; the root argument stays positive
        send_cols(-32768, 0, 0, 0, 32767, 0, 0, 0, -32768);
        send_cols(-32768, 0, 0, 0, -32768, 0, 0, 0, 32767);
        send_cols(32767, 0, 0, 0, -32768, 0, 0, 0, -32768);
        send_cols(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
        send_cols(32767, -32768, -32768, -32768, 32767, -32768, -32768, -32768, 32767);
        send_cols(-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768);
        send_cols(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 1);
        send_matrix({144{1'b1}});
        send_matrix({9{16'h5555}});
        send_matrix({9{16'haaaa}});
    endtask

    task automatic test_rotations();
        // near-orthogonal matrices from small random perturbations of signed axis permutations
        int v[9];
        for (int n = 0; n < 700; n++) begin
            int p, sg;
            p = $urandom_range(0, 5);
            for (int i = 0; i < 9; i++) v[i] = $urandom_range(0, 4000) - 2000;
            sg = $urandom_range(0, 7);
            case (p)
                0: begin v[0] += 15000; v[4] += 15000; v[8] += 15000; end
                1: begin v[1] += 15000; v[5] += 15000; v[6] += 15000; end
                2: begin v[2] += 15000; v[3] += 15000; v[7] += 15000; end
                3: begin v[0] += 15000; v[5] += 15000; v[7] -= 15000; end
                4: begin v[8] += 15000; v[0] -= 15000; v[4] -= 15000; end
                default: begin v[4] += 15000; v[0] -= 15000; v[8] -= 15000; end
            endcase
            if (sg[0]) for (int i = 0; i < 3; i++) v[i] = -v[i];
            send_cols(v[0], v[1], v[2], v[3], v[4], v[5], v[6], v[7], v[8]);
        end
    endtask

    task automatic test_random_raw();
        logic [143:0] d;
        for (int n = 0; n < 330; n++) begin
            for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom);
            send_matrix(d);
        end
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        sink_run = 1'b1;
        test_directed();
        test_rotations();
        test_random_raw();
        s_tvalid <= 1'b0;
        while (quat_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (errors == 0) $display("tb_rotation_matrix_to_quaternion OK");
        else $display("tb_rotation_matrix_to_quaternion NOT OK");
        $finish;
    end
endmodule
